// ----- rtl/stbs_pkg.sv -----
package stbs_pkg;

   // fixed field widths
   localparam int KEY_W      = 32;
   localparam int INDEX_W    = 10;
   localparam int STEP_W     = 4;
   localparam int COUNT_W    = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRIES_IN_USE = 2'd0;

   // status from the probe unit to the sequencer
   typedef struct packed {
      logic hit;
      logic done;
   } stbs_probe_flags_type;

endpackage

// ----- rtl/sorted_table_binary_search.sv -----
// Search: one table read per step but for a failed bounds check; the result
// strobe is registered and rises once the hit or the failed check is found.
// Load: stored on acceptance; below depth 1024 the index is wrapped in ST_WRAP first, with busy high.
// Next word is taken in the cycle the result strobe shows; the receiver cannot stall.
// Reset (synchronous, high) clears control and entries_in_use; the table is left
// as is and needs no clearing pass.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // command side
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [stbs_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic signed [stbs_pkg::KEY_W-1:0]  req_value,
   // results
   output logic                               rsp_strobe,
   output logic                               rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]       rsp_position,
   output logic [stbs_pkg::STEP_W-1:0]        rsp_step_count,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import stbs_pkg::*;

   localparam int AW      = $clog2(TABLE_DEPTH);
   // searchable count is entries_in_use saturated at the depth
   localparam int CNT_MAX = (TABLE_DEPTH < (1 << COUNT_W) - 1) ? TABLE_DEPTH
                                                               : (1 << COUNT_W) - 1;
   localparam int CW      = $clog2(CNT_MAX + 1);
   // a load index wraps only when the table is shallower than the index range
   localparam bit NEED_WRAP = TABLE_DEPTH < (1 << INDEX_W);
   localparam int WRAP_W    = 2 * INDEX_W;
   // quotient of index by depth: multiply by a rounded-up reciprocal, exact
   // for every 10-bit index
   localparam int RECIP_S = INDEX_W + AW;
   localparam int RECIP_W = INDEX_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'(((1 << RECIP_S) + TABLE_DEPTH - 1) / TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_WRAP   = 2'd2;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   logic [1:0]               state_ff,    state_in;
   logic [COUNT_W-1:0]       entries_ff,  entries_in;
   logic signed [KEY_W-1:0]  key_ff,      key_in;
   logic [CW-1:0]            left_ff,     left_in;
   logic [CW-1:0]            hi_ff,       hi_in;
   logic [CW-1:0]            mid_ff,      mid_in;
   logic [STEP_W-1:0]        steps_ff,    steps_in;
   logic [INDEX_W-1:0]       idx_ff,      idx_in;
   logic [INDEX_W-1:0]       quot_ff,     quot_in;
   logic                     strobe_ff,   strobe_in;
   logic                     found_ff,    found_in;
   logic [INDEX_W-1:0]       pos_ff,      pos_in;
   logic [STEP_W-1:0]        count_ff,    count_in;

   // table port
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [KEY_W-1:0]         wr_data, rd_data;

   // probe unit
   logic                     probe_first;
   logic [CW-1:0]            count;
   logic signed [KEY_W-1:0]  probe_key;
   stbs_probe_flags_type     flags;
   logic [CW-1:0]            left_next, hi_next, mid_next;

   // index wrap: quotient on the accept cycle, remainder on the next
   logic [INDEX_W+RECIP_W-1:0] recip_prod;
   logic [INDEX_W-1:0]         idx_quot;
   logic [WRAP_W-1:0]          wrap_prod;
   logic [INDEX_W-1:0]         idx_red;

   logic                     accept, csr_write;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_write = psel && penable && pwrite && pready;

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign prdata = (paddr == REG_ENTRIES_IN_USE)
                 ? {{(CSR_DATA_W - COUNT_W){1'b0}}, entries_ff}
                 : '0;

   assign count = (entries_ff > COUNT_W'(CNT_MAX)) ? CW'(CNT_MAX) : CW'(entries_ff);

   // ---------------------------------------------------------------
   // shared step unit
   // ---------------------------------------------------------------
   assign probe_first = (state_ff == ST_IDLE);
   assign probe_key   = probe_first ? req_value : key_ff;

   stbs_probe #(.CW(CW)) u_probe (
      .first     (probe_first),
      .count     (count),
      .left      (left_ff),
      .hi        (hi_ff),
      .mid       (mid_ff),
      .key       (probe_key),
      .entry     (rd_data),
      .flags     (flags),
      .left_next (left_next),
      .hi_next   (hi_next),
      .mid_next  (mid_next)
   );

   assign recip_prod = {{RECIP_W{1'b0}}, req_entry_index} * {{INDEX_W{1'b0}}, RECIP_M};
   assign idx_quot   = INDEX_W'(recip_prod >> RECIP_S);
   assign wrap_prod  = {{INDEX_W{1'b0}}, quot_ff} * {{INDEX_W{1'b0}}, INDEX_W'(TABLE_DEPTH)};
   assign idx_red    = idx_ff - wrap_prod[INDEX_W-1:0];

   stbs_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      entries_in = entries_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      steps_in  = steps_ff;
      idx_in    = idx_ff;
      quot_in   = quot_ff;
      strobe_in = 1'b0;
      found_in  = found_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(req_entry_index);
      wr_data   = req_value;
      rd_en     = 1'b0;
      rd_addr   = AW'(mid_next);

      if (csr_write && (paddr == REG_ENTRIES_IN_USE)) begin
         entries_in = pwdata[COUNT_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_op == OP_LOAD) begin
                  if (NEED_WRAP) begin
                     idx_in   = req_entry_index;
                     key_in   = req_value;
                     quot_in  = idx_quot;
                     state_in = ST_WRAP;
                  end else begin
                     wr_en = 1'b1;
                  end
               end else if (flags.done) begin
                  // empty table: the bounds check alone is the one step
                  strobe_in = 1'b1;
                  found_in  = 1'b0;
                  pos_in    = '0;
                  count_in  = STEP_W'(1);
               end else begin
                  rd_en    = 1'b1;
                  key_in   = req_value;
                  left_in  = left_next;
                  hi_in    = hi_next;
                  mid_in   = mid_next;
                  steps_in = STEP_W'(1);
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            priority if (flags.hit) begin
               strobe_in = 1'b1;
               found_in  = 1'b1;
               pos_in    = INDEX_W'(mid_ff);
               count_in  = steps_ff;
               state_in  = ST_IDLE;
            end else if (flags.done) begin
               // failed bounds check is a step of its own
               strobe_in = 1'b1;
               found_in  = 1'b0;
               pos_in    = '0;
               count_in  = steps_ff + STEP_W'(1);
               state_in  = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               left_in  = left_next;
               hi_in    = hi_next;
               mid_in   = mid_next;
               steps_in = steps_ff + STEP_W'(1);
            end
         end

         ST_WRAP: begin
            // index minus quotient times depth, then store
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_red);
            wr_data  = key_ff;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         entries_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         entries_ff <= entries_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      left_ff  <= left_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      steps_ff <= steps_in;
      idx_ff   <= idx_in;
      quot_ff  <= quot_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      count_ff <= count_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_found      = found_ff;
   assign rsp_position   = pos_ff;
   assign rsp_step_count = count_ff;

endmodule

// ----- rtl/stbs_table.sv -----
module stbs_table #(
   parameter int DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW    = $clog2(stbs_pkg::DEFAULT_TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [stbs_pkg::KEY_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [stbs_pkg::KEY_W-1:0]    rd_data
);
   import stbs_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stbs_probe.sv -----
// One binary search step: compare, narrow the window, pick the next midpoint.
// Window is [left, hi), hi exclusive.
module stbs_probe #(
   parameter int CW = stbs_pkg::COUNT_W
) (
   input  logic                               first,
   input  logic [CW-1:0]                      count,
   input  logic [CW-1:0]                      left,
   input  logic [CW-1:0]                      hi,
   input  logic [CW-1:0]                      mid,
   input  logic signed [stbs_pkg::KEY_W-1:0]  key,
   input  logic signed [stbs_pkg::KEY_W-1:0]  entry,
   output stbs_pkg::stbs_probe_flags_type     flags,
   output logic [CW-1:0]                      left_next,
   output logic [CW-1:0]                      hi_next,
   output logic [CW-1:0]                      mid_next
);
   import stbs_pkg::*;

   logic [CW:0] sum;

   always_comb begin
      priority if (first) begin
         left_next = '0;
         hi_next   = count;
      end else if (key < entry) begin
         left_next = left;
         hi_next   = mid;
      end else begin
         left_next = mid + CW'(1);
         hi_next   = hi;
      end
   end

   // floor((left + hi - 1) / 2); meaningless when the window is empty
   assign sum       = {1'b0, left_next} + {1'b0, hi_next} - (CW+1)'(1);
   assign mid_next  = sum[CW:1];

   assign flags.hit  = !first && (key == entry);
   assign flags.done = !(left_next < hi_next);

endmodule

// ----- rtl/stbs_checker.sv -----
module stbs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_op,
   input logic                             rsp_strobe,
   input logic                             rsp_found,
   input logic [stbs_pkg::INDEX_W-1:0]     rsp_position
);
   import stbs_pkg::*;

   // a miss always reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_position == '0)
      else $error("miss with non-zero position");

   // a load never yields a word
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_LOAD) |=> !rsp_strobe)
      else $error("result after a load");

   // a search either answers at once or keeps the block busy
   a_search_runs: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_SEARCH) |=> busy || rsp_strobe)
      else $error("search dropped");

   // a result needs a search in flight or just taken
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || ($past(start) && $past(req_op) == OP_SEARCH))
      else $error("result without a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_op       (req_op),
   .rsp_strobe   (rsp_strobe),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);

// ----- test/tb_sorted_table_binary_search.sv -----
module tb_sorted_table_binary_search;
   import stbs_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;

   // Longest quiet spell of a correct run is a settle, a register write and
   // read-back, one full search and a send gap.
   localparam int STALL_LIMIT = 2000;

   // A load at a small depth may still be wrapping its index after the last
   // search result, so let the block run dry for this long before a write.
   localparam int SETTLE_CYCLES = 16;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   // ascending seed table for the directed part
   localparam logic signed [KEY_W-1:0] SEED_KEYS [8] =
      '{KEY_MIN, -1000, -1, 0, 1, 77, 1000, KEY_MAX};

   // hits at both ends and the middle, misses in the gaps next to the ends and in one inner gap
   localparam logic signed [KEY_W-1:0] PROBE_KEYS [8] =
      '{KEY_MIN, KEY_MAX, 0, -1, 77, 2, KEY_MIN + 1, KEY_MAX - 1};

   typedef struct {
      logic                 found;
      logic [INDEX_W-1:0]   position;
      logic [STEP_W-1:0]    steps;
   } search_answer_type;

   // Shadow of the table and the register, plus the answers still owed.
   class search_scoreboard;
      logic signed [KEY_W-1:0] entries [DEPTH];
      logic [COUNT_W-1:0]      live_count;
      search_answer_type       owed[$];
      int                      errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         live_count = '0;
         errors     = 0;
      endfunction

      function void set_count(input logic [COUNT_W-1:0] n);
         live_count = n;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Called for each accepted word: a load updates the shadow, a search
      // walks the window exactly as the block must and queues the answer.
      function void note_word(input logic op, input logic [INDEX_W-1:0] idx,
                              input logic signed [KEY_W-1:0] key);
         search_answer_type ans;
         int             lo, hi, mid, span;
         logic           done;
         logic signed [KEY_W-1:0] probe;
         if (op == OP_LOAD) begin
            entries[idx % DEPTH] = key;
         end else begin
            span = (live_count > DEPTH) ? DEPTH : int'(live_count);
            lo = 0;
            hi = span - 1;
            ans = '{found: 1'b0, position: '0, steps: '0};
            done = 1'b0;
            while (!done) begin
               ans.steps++;
               if (lo > hi) begin
                  done = 1'b1;   // empty window still costs a step
               end else begin
                  mid   = lo + (hi - lo) / 2;
                  probe = entries[mid % DEPTH];
                  if (probe == key) begin
                     ans.found    = 1'b1;
                     ans.position = INDEX_W'(mid);
                     done         = 1'b1;
                  end else if (key < probe) begin
                     hi = mid - 1;
                  end else begin
                     lo = mid + 1;
                  end
               end
            end
            owed.push_back(ans);
         end
      endfunction

      function void check_answer(input logic found, input logic [INDEX_W-1:0] position,
                                 input logic [STEP_W-1:0] steps);
         search_answer_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result word found=%0b position=%0d steps=%0d",
                     $time, found, position, steps);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            errors++;
         end
         if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, position);
            errors++;
         end
         if (steps !== want.steps) begin
            $display("%0t: step_count expected %0d actual %0d", $time, want.steps, steps);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_op = OP_LOAD;
   logic [INDEX_W-1:0]        req_entry_index = '0;
   logic signed [KEY_W-1:0]   req_value = '0;
   logic                      rsp_strobe;
   logic                      rsp_found;
   logic [INDEX_W-1:0]        rsp_position;
   logic [STEP_W-1:0]         rsp_step_count;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   search_scoreboard sb;
   bit               start_held = 1'b0;   // start was last driven high
   int               words_sent = 0;
   int               stall_cycles = 0;

   sorted_table_binary_search dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_step_count  (rsp_step_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Results cannot be held off: every strobed cycle is a word taken.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_answer(rsp_found, rsp_position, rsp_step_count);
      end
   end

   // Watchdog: cycles with neither a word taken in nor a result out.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("[sorted_table_binary_search] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one word and hold it until the block takes it. start stays
   // high on return so a back-to-back word needs no extra edge.
   task automatic send_word(input logic op, input logic [INDEX_W-1:0] idx,
                            input logic signed [KEY_W-1:0] key);
      req_op          <= op;
      req_entry_index <= idx;
      req_value       <= key;
      start           <= 1'b1;
      start_held       = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_word(op, idx, key);
      words_sent++;
   endtask

   task automatic go_quiet();
      if (start_held) begin
         start     <= 1'b0;
         start_held = 1'b0;
         @(posedge clock);
      end
   endtask

   // Random send gaps: each cycle idles with odds of about 29 in a hundred,
   // so gaps are mostly short with the odd long one. One long run has none.
   task automatic send_gap();
      if (words_sent >= 600 && words_sent < 900) return;
      if ($urandom_range(0, 99) < 29) begin
         go_quiet();
         while ($urandom_range(0, 99) < 29) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      go_quiet();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // access edge: pready is tied high
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Change entries_in_use with the block idle, then read it back. Upper
   // data bits are sometimes junk; only the low 11 are kept.
   task automatic set_entries(input logic [COUNT_W-1:0] n);
      logic [CSR_DATA_W-1:0] wdata, rdata;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      wdata = {($urandom_range(0, 3) == 0) ? (CSR_DATA_W - COUNT_W)'($urandom)
                                           : (CSR_DATA_W - COUNT_W)'(0), n};
      csr_access(1'b1, REG_ENTRIES_IN_USE, wdata, rdata);
      sb.set_count(n);
      csr_access(1'b0, REG_ENTRIES_IN_USE, '0, rdata);
      if (rdata !== CSR_DATA_W'(n)) begin
         $display("%0t: entries_in_use read expected %0d actual %0d", $time, n, rdata);
         sb.errors++;
      end
   endtask

   // Mostly keys that sit in the live window, some neighbours of them,
   // some free keys and the two extremes.
   function automatic logic signed [KEY_W-1:0] choose_key(input int span);
      int                      r;
      logic signed [KEY_W-1:0] e;
      r = $urandom_range(0, 19);
      if (span == 0 || r < 2) return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      e = sb.entries[$urandom_range(0, span - 1)];
      if (r < 12) return e;
      if (r < 14) return e + 1;
      if (r < 16) return e - 1;
      return $urandom;
   endfunction

   // One sorted table of random size, loaded in scrambled order, then
   // searched; now and then a stray load leaves the table out of order.
   task automatic small_phase();
      int  n, r, i, searches;
      bit  narrow;
      int  keys[$];
      int  order[$];
      r      = $urandom_range(0, 9);
      n      = (r < 6) ? $urandom_range(1, 16) : ((r < 9) ? $urandom_range(17, 128) : 0);
      narrow = ($urandom_range(0, 3) == 0);   // tight range gives duplicates
      for (i = 0; i < n; i++) begin
         keys.push_back(narrow ? int'($urandom_range(0, 40)) - 20 : int'($urandom));
         order.push_back(i);
      end
      keys.sort();
      order.shuffle();
      set_entries(COUNT_W'(n));
      foreach (order[i]) begin
         send_word(OP_LOAD, INDEX_W'(order[i]), keys[order[i]]);
         send_gap();
      end
      searches = $urandom_range(10, 40);
      for (i = 0; i < searches; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_word(OP_LOAD, INDEX_W'($urandom_range(0, n > 0 ? n - 1 : 0)), $urandom);
         end else begin
            send_word(OP_SEARCH, INDEX_W'($urandom), choose_key(n));
         end
         send_gap();
         if ($urandom_range(0, 49) == 0) drain_results();
      end
   endtask

   // Whole table loaded, then searches at full depth, with counts that
   // saturate to it and with counts below it.
   task automatic full_table_phase();
      int                 i, k, span;
      int                 keys[$];
      int                 order[$];
      logic [COUNT_W-1:0] counts [5];
      int                 rounds [5];
      counts = '{11'd1024, 11'd2047, 11'd1025, 11'd1023, 11'd0};
      rounds = '{30, 30, 20, 20, 5};
      for (i = 0; i < DEPTH; i++) begin
         keys.push_back(int'($urandom));
         order.push_back(i);
      end
      keys.sort();
      keys[0]         = KEY_MIN;
      keys[DEPTH - 1] = KEY_MAX;
      order.shuffle();
      set_entries(COUNT_W'(DEPTH));
      foreach (order[i]) begin
         send_word(OP_LOAD, INDEX_W'(order[i]), keys[order[i]]);
         send_gap();
      end
      for (k = 0; k < 5; k++) begin
         set_entries(counts[k]);
         span = (counts[k] > DEPTH) ? DEPTH : int'(counts[k]);
         for (i = 0; i < rounds[k]; i++) begin
            send_word(OP_SEARCH, INDEX_W'($urandom), choose_key(span));
            send_gap();
         end
      end
   endtask

   initial begin
      int i;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty window straight out of reset: a miss in one step.
      send_word(OP_SEARCH, '0, 32'sd0);
      send_gap();
      send_word(OP_SEARCH, '1, KEY_MIN);
      send_gap();

      for (i = 0; i < 8; i++) begin
         send_word(OP_LOAD, INDEX_W'(i), SEED_KEYS[i]);
         send_gap();
      end
      set_entries(11'd8);
      for (i = 0; i < 8; i++) begin
         send_word(OP_SEARCH, INDEX_W'(i * 131), PROBE_KEYS[i]);
         send_gap();
      end

      // single-entry window: hit on the first probe, miss on the second step
      set_entries(11'd1);
      send_word(OP_SEARCH, '0, KEY_MIN);
      send_gap();
      send_word(OP_SEARCH, '0, 32'sd5);
      send_gap();

      // break the ordering and search through it
      send_word(OP_LOAD, 10'd3, KEY_MAX);
      send_gap();
      set_entries(11'd8);
      send_word(OP_SEARCH, '0, KEY_MAX);
      send_gap();
      send_word(OP_SEARCH, '0, 32'sd0);
      send_gap();

      while (words_sent < 60) small_phase();
      full_table_phase();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[sorted_table_binary_search] OK");
      end else begin
         $display("[sorted_table_binary_search] ERROR");
      end
      $finish;
   end

endmodule
